/* sv/dmc_pkg.sv */
package dmc_pkg;

  // widths fixed by the item fields and the configuration registers
  localparam int RAND_W      = 31;
  localparam int CFG_W       = 8;
  localparam int OUT_COORD_W = 7;
  localparam int SIDE_MIN    = 5;
  localparam int SIDE_RESET  = 21;

  // configuration register indexes
  localparam logic CFG_GRID_WIDTH  = 1'b0;
  localparam logic CFG_GRID_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    EV_START = 2'd0,
    EV_CARVE = 2'd1,
    EV_BACK  = 2'd2,
    EV_DONE  = 2'd3
  } event_kind_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_WALK  = 2'd1,
    PH_DONE  = 2'd2,
    PH_SPARE = 2'd3
  } walk_phase_t;

  // neighbor directions, in search order
  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_t;

  // handshake between the sequencer and the remainder unit
  typedef struct packed {
    logic start;
  } mod_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_sts_t;

endpackage

/* sv/dmc_mod_unit.sv */
module dmc_mod_unit #(
  parameter int DW = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dmc_pkg::mod_ctl_t           ctl,
  input  logic [dmc_pkg::RAND_W-1:0]  dividend,
  input  logic [DW-1:0]               divisor,
  output dmc_pkg::mod_sts_t           sts,
  output logic [DW-1:0]               remainder
);
  import dmc_pkg::*;

  localparam int CNTW = $clog2(RAND_W);

  logic              busy_r;
  logic              done_r;
  logic [CNTW-1:0]   cnt_r;
  logic [RAND_W-1:0] dvd_r;
  logic [DW-1:0]     dsr_r;
  logic [DW-1:0]     rem_r;
  logic [DW:0]       shifted;
  logic [DW:0]       diff;
  logic [DW-1:0]     rem_nxt;

  // restoring remainder, one dividend bit a cycle
  always_comb begin
    shifted = {rem_r, dvd_r[RAND_W-1]};
    diff    = shifted - {1'b0, dsr_r};
    rem_nxt = (shifted >= {1'b0, dsr_r}) ? diff[DW-1:0] : shifted[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(RAND_W - 1);
        dvd_r  <= dividend;
        dsr_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        dvd_r <= dvd_r << 1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - CNTW'(1);
        end
      end
    end
  end

  assign sts.busy  = busy_r;
  assign sts.done  = done_r;
  assign remainder = rem_r;

endmodule

/* sv/dfs_maze_carver.sv */
// randomized depth-first maze carver, one walk step per input item, one or two result items each
// work per item: the first item runs two remainders, a carving step 4 serial cell reads plus
// one remainder, a backtrack the 4 cell reads plus a stack read (none when it empties the
// stack), a finished item neither
// throughput: one item at a time, set by the shared bit-serial remainder unit and the single
// cell-memory read port
// reset: synchronous active-low; afterwards a clearing pass over all 2^(2*ceil(log2 MAX_SIDE)) cell
// addresses (16384 at the default) walls every cell, and no item is taken until it ends
module dfs_maze_carver #(
  parameter int MAX_SIDE    = 128,
  parameter int STACK_DEPTH = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration writes
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [dmc_pkg::CFG_W-1:0]        cfg_wdata,
  // input items
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [dmc_pkg::RAND_W-1:0]       in_random_a,
  input  logic [dmc_pkg::RAND_W-1:0]       in_random_b,
  // result items
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_event_kind,
  output logic [dmc_pkg::OUT_COORD_W-1:0]  out_cell_column,
  output logic [dmc_pkg::OUT_COORD_W-1:0]  out_cell_row,
  output logic                             out_last_of_step
);
  import dmc_pkg::*;

  localparam int CW    = $clog2(MAX_SIDE);          // coordinate bits
  localparam int SW    = $clog2(MAX_SIDE + 1);      // side length bits
  localparam int LW    = SW + 1;                    // bounds compare width
  localparam int AW    = 2 * CW;                    // cell address bits
  localparam int SAW   = $clog2(STACK_DEPTH);       // stack index bits
  localparam int DPW   = $clog2(STACK_DEPTH + 1);   // stack fill bits
  localparam int CELLS = 2 ** AW;

  localparam logic [CFG_W:0] SIDE_MAX_V = (CFG_W + 1)'(MAX_SIDE);
  localparam logic [CFG_W:0] SIDE_MIN_V = (CFG_W + 1)'(SIDE_MIN);

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_MODC_GO,
    S_MODC_WAIT,
    S_MODR_GO,
    S_MODR_WAIT,
    S_START,
    S_NB_RD,
    S_NB_CHK,
    S_DECIDE,
    S_MODP_GO,
    S_MODP_WAIT,
    S_CARVE_MID,
    S_CARVE_TGT,
    S_BACK,
    S_POP_RD,
    S_POP,
    S_END_BACK,
    S_END_DONE,
    S_FIN
  } state_t;

  // configuration
  logic [CFG_W-1:0] grid_width_r;
  logic [CFG_W-1:0] grid_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= CFG_W'(SIDE_RESET);
      grid_height_r <= CFG_W'(SIDE_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRID_WIDTH:  grid_width_r  <= cfg_wdata;
        CFG_GRID_HEIGHT: grid_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sides clamped into the supported range
  function automatic logic [SW-1:0] eff_side(input logic [CFG_W-1:0] v);
    logic [CFG_W:0] x;
    x = {1'b0, v};
    if (x < SIDE_MIN_V) x = SIDE_MIN_V;
    if (x > SIDE_MAX_V) x = SIDE_MAX_V;
    return SW'(x);
  endfunction

  // walk state
  state_t            state_r;
  walk_phase_t       phase_r;
  logic [AW-1:0]     clr_r;
  logic [RAND_W-1:0] ra_r;
  logic [RAND_W-1:0] rb_r;
  logic [SW-1:0]     w_r;
  logic [SW-1:0]     h_r;
  logic [DPW-1:0]    depth_r;
  logic [CW-1:0]     cur_col_r;
  logic [CW-1:0]     cur_row_r;
  logic [CW-1:0]     start_col_r;
  logic [CW-1:0]     start_row_r;
  dir_t              dir_r;
  logic [3:0]        open_mask_r;
  logic              nb_inb_r;

  // result register
  logic                   out_valid_r;
  event_kind_t            out_kind_r;
  logic [OUT_COORD_W-1:0] out_col_r;
  logic [OUT_COORD_W-1:0] out_row_r;
  logic                   out_last_r;
  logic                   out_free;
  logic                   out_load;

  assign out_free = !out_valid_r || !out_stall;

  // states that hand a result item to the result register once it is free
  assign out_load = out_free && (state_r inside {S_START, S_CARVE_MID, S_CARVE_TGT, S_POP,
                                                 S_END_BACK, S_END_DONE, S_FIN});

  // cell memory, one bit per cell, 1 = passage
  logic            map_mem [CELLS];
  logic            map_we;
  logic [AW-1:0]   map_waddr;
  logic            map_wbit;
  logic [AW-1:0]   map_raddr;
  logic            map_rdata_r;

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_waddr] <= map_wbit;
    map_rdata_r <= map_mem[map_raddr];
  end

  // path stack of cell addresses
  logic [AW-1:0]   stack_mem [STACK_DEPTH];
  logic            stack_we;
  logic [SAW-1:0]  stack_waddr;
  logic [AW-1:0]   stack_wdata;
  logic [DPW-1:0]  depth_m1;
  logic [AW-1:0]   stack_rdata_r;

  assign depth_m1 = depth_r - DPW'(1);

  always_ff @(posedge clk) begin
    if (stack_we) stack_mem[stack_waddr] <= stack_wdata;
    stack_rdata_r <= stack_mem[depth_m1[SAW-1:0]];
  end

  // neighbor two steps away in direction dir_r, and the wall cell between
  logic          nb_inb;
  logic [CW-1:0] nb_tcol;
  logic [CW-1:0] nb_trow;
  logic [CW-1:0] nb_mcol;
  logic [CW-1:0] nb_mrow;
  logic          col_ok;
  logic          row_ok;

  // a shrunk grid can leave the current cell outside it, so every target
  // coordinate is checked against both edges
  always_comb begin
    col_ok  = LW'(cur_col_r) < LW'(w_r);
    row_ok  = LW'(cur_row_r) < LW'(h_r);
    nb_tcol = cur_col_r;
    nb_trow = cur_row_r;
    nb_mcol = cur_col_r;
    nb_mrow = cur_row_r;
    unique case (dir_r)
      DIR_UP: begin
        nb_inb  = col_ok && (cur_row_r >= CW'(2)) &&
                  (LW'(cur_row_r) < (LW'(h_r) + LW'(2)));
        nb_trow = cur_row_r - CW'(2);
        nb_mrow = cur_row_r - CW'(1);
      end
      DIR_DOWN: begin
        nb_inb  = col_ok && ((LW'(cur_row_r) + LW'(2)) < LW'(h_r));
        nb_trow = cur_row_r + CW'(2);
        nb_mrow = cur_row_r + CW'(1);
      end
      DIR_LEFT: begin
        nb_inb  = row_ok && (cur_col_r >= CW'(2)) &&
                  (LW'(cur_col_r) < (LW'(w_r) + LW'(2)));
        nb_tcol = cur_col_r - CW'(2);
        nb_mcol = cur_col_r - CW'(1);
      end
      DIR_RIGHT: begin
        nb_inb  = row_ok && ((LW'(cur_col_r) + LW'(2)) < LW'(w_r));
        nb_tcol = cur_col_r + CW'(2);
        nb_mcol = cur_col_r + CW'(1);
      end
      default: nb_inb = 1'b0;
    endcase
  end

  // candidate count and the pick-th open direction
  logic [2:0]    open_cnt;
  logic [1:0]    pick;
  dir_t          pick_dir;
  logic [2:0]    seen;
  logic          found;

  assign open_cnt = 3'(open_mask_r[0]) + 3'(open_mask_r[1])
                  + 3'(open_mask_r[2]) + 3'(open_mask_r[3]);

  // shared remainder unit
  mod_ctl_t       mod_ctl;
  mod_sts_t       mod_sts;
  logic [RAND_W-1:0] mod_dvd;
  logic [SW-1:0]  mod_dsr;
  logic [SW-1:0]  mod_rem;

  always_comb begin
    mod_ctl.start = (state_r == S_MODC_GO) || (state_r == S_MODR_GO) ||
                    (state_r == S_MODP_GO);
    mod_dvd = (state_r == S_MODR_GO) ? rb_r : ra_r;
    unique case (state_r)
      S_MODC_GO: mod_dsr = w_r;
      S_MODR_GO: mod_dsr = h_r;
      default:   mod_dsr = SW'(open_cnt);
    endcase
  end

  dmc_mod_unit #(
    .DW(SW)
  ) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (mod_ctl),
    .dividend  (mod_dvd),
    .divisor   (mod_dsr),
    .sts       (mod_sts),
    .remainder (mod_rem)
  );

  always_comb begin
    pick     = mod_rem[1:0];
    pick_dir = DIR_UP;
    seen     = '0;
    found    = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (open_mask_r[k]) begin
        if (!found && (seen == 3'(pick))) begin
          pick_dir = dir_t'(2'(k));
          found    = 1'b1;
        end
        seen = seen + 3'd1;
      end
    end
  end

  // memory write and read ports
  always_comb begin
    map_we      = 1'b0;
    map_waddr   = {nb_mrow, nb_mcol};
    map_wbit    = 1'b1;
    stack_we    = 1'b0;
    stack_waddr = depth_r[SAW-1:0];
    stack_wdata = {nb_trow, nb_tcol};
    map_raddr   = {nb_trow, nb_tcol};
    unique case (state_r)
      S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_r;
        map_wbit  = 1'b0;
      end
      S_START: begin
        map_we      = out_free;
        map_waddr   = {start_row_r, start_col_r};
        stack_we    = out_free;
        stack_waddr = '0;
        stack_wdata = {start_row_r, start_col_r};
      end
      S_CARVE_MID: map_we = out_free;
      S_CARVE_TGT: begin
        map_we    = out_free;
        map_waddr = {nb_trow, nb_tcol};
        stack_we  = out_free;
      end
      default: ;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      phase_r     <= PH_IDLE;
      clr_r       <= '0;
      depth_r     <= '0;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      dir_r       <= DIR_UP;
      open_mask_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == {AW{1'b1}}) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            ra_r        <= in_random_a;
            rb_r        <= in_random_b;
            w_r         <= eff_side(grid_width_r);
            h_r         <= eff_side(grid_height_r);
            dir_r       <= DIR_UP;
            open_mask_r <= '0;
            unique case (phase_r)
              PH_IDLE: state_r <= S_MODC_GO;
              PH_WALK: state_r <= S_NB_RD;
              default: state_r <= S_FIN;
            endcase
          end
        end
        S_MODC_GO: state_r <= S_MODC_WAIT;
        S_MODC_WAIT: begin
          if (mod_sts.done) begin
            start_col_r <= CW'(mod_rem);
            state_r     <= S_MODR_GO;
          end
        end
        S_MODR_GO: state_r <= S_MODR_WAIT;
        S_MODR_WAIT: begin
          if (mod_sts.done) begin
            start_row_r <= CW'(mod_rem);
            state_r     <= S_START;
          end
        end
        S_START: begin
          if (out_free) begin
            depth_r     <= DPW'(1);
            cur_col_r   <= start_col_r;
            cur_row_r   <= start_row_r;
            phase_r     <= PH_WALK;
            out_kind_r  <= EV_START;
            out_col_r   <= OUT_COORD_W'(start_col_r);
            out_row_r   <= OUT_COORD_W'(start_row_r);
            out_last_r  <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        // read the target cell, then judge it on the next cycle
        S_NB_RD: begin
          nb_inb_r <= nb_inb;
          state_r  <= S_NB_CHK;
        end
        S_NB_CHK: begin
          open_mask_r[dir_r] <= nb_inb_r && !map_rdata_r;
          if (dir_r == DIR_RIGHT) begin
            state_r <= S_DECIDE;
          end else begin
            dir_r   <= dir_t'(dir_r + 2'd1);
            state_r <= S_NB_RD;
          end
        end
        S_DECIDE: begin
          if ((open_cnt != 3'd0) && (depth_r < DPW'(STACK_DEPTH))) state_r <= S_MODP_GO;
          else state_r <= S_BACK;
        end
        S_MODP_GO: state_r <= S_MODP_WAIT;
        S_MODP_WAIT: begin
          if (mod_sts.done) begin
            dir_r   <= pick_dir;
            state_r <= S_CARVE_MID;
          end
        end
        S_CARVE_MID: begin
          if (out_free) begin
            out_kind_r  <= EV_CARVE;
            out_col_r   <= OUT_COORD_W'(nb_mcol);
            out_row_r   <= OUT_COORD_W'(nb_mrow);
            out_last_r  <= 1'b0;
            state_r     <= S_CARVE_TGT;
          end
        end
        S_CARVE_TGT: begin
          if (out_free) begin
            depth_r     <= depth_r + DPW'(1);
            cur_col_r   <= nb_tcol;
            cur_row_r   <= nb_trow;
            out_kind_r  <= EV_CARVE;
            out_col_r   <= OUT_COORD_W'(nb_tcol);
            out_row_r   <= OUT_COORD_W'(nb_trow);
            out_last_r  <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        // pop; an emptied stack ends the walk
        S_BACK: begin
          if (depth_r > DPW'(1)) begin
            depth_r <= depth_m1;
            state_r <= S_POP_RD;
          end else begin
            depth_r <= '0;
            phase_r <= PH_DONE;
            state_r <= S_END_BACK;
          end
        end
        S_POP_RD: state_r <= S_POP;
        S_POP: begin
          cur_row_r <= stack_rdata_r[AW-1:CW];
          cur_col_r <= stack_rdata_r[CW-1:0];
          if (out_free) begin
            out_kind_r  <= EV_BACK;
            out_col_r   <= '0;
            out_row_r   <= '0;
            out_last_r  <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_END_BACK: begin
          if (out_free) begin
            out_kind_r  <= EV_BACK;
            out_col_r   <= '0;
            out_row_r   <= '0;
            out_last_r  <= 1'b0;
            state_r     <= S_END_DONE;
          end
        end
        S_END_DONE, S_FIN: begin
          if (out_free) begin
            out_kind_r  <= EV_DONE;
            out_col_r   <= '0;
            out_row_r   <= '0;
            out_last_r  <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_kind   = out_kind_r;
  assign out_cell_column  = out_col_r;
  assign out_cell_row     = out_row_r;
  assign out_last_of_step = out_last_r;

  // stack fill never passes the stack size
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DPW'(STACK_DEPTH))
    else $error("stack fill beyond stack size");

  // a walk in progress always has a current cell on the stack
  a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && phase_r == PH_WALK) |-> depth_r != '0)
    else $error("walking with an empty stack");

  // a finished walk has emptied its stack
  a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DONE) |-> depth_r == '0)
    else $error("finished with cells still stacked");

  // remainder results only arrive while the sequencer waits for them
  a_mod_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mod_sts.done |-> (state_r == S_MODC_WAIT || state_r == S_MODR_WAIT ||
                      state_r == S_MODP_WAIT))
    else $error("remainder finished outside a wait state");

  // no new remainder is started while the unit is still busy
  a_mod_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mod_ctl.start |-> !mod_sts.busy)
    else $error("remainder started while busy");

endmodule
